>>> rtl/art_pkg.sv
// Shared types, constants and the arctangent table for the rotate-and-translate block.
package art_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 32;

  // The arctangent table has 32 entries, so at most 32 cells are built.
  localparam int NUM_ITER = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SAT_W    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  localparam int IDX_W      = 5;
  localparam int PT_W       = 32;
  localparam int ANGLE_W    = 16;
  localparam int CS_W       = 34;
  localparam int ANG_W      = 33;
  localparam int ROT_W      = 34;
  localparam int SUM_W      = ROT_W + 1;
  localparam int PROD_W     = CS_W + PT_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_SHIFT = 30;

  localparam logic signed [CS_W-1:0]  INV_GAIN = CS_W'(32'h26DD3B6A);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [ANG_W-1:0] Z_BOUND  = ANG_W'(1) <<< FRAC_SHIFT;
  localparam logic signed [SUM_W-1:0] SAT_HI   = (SUM_W'(1) <<< (SAT_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO   = -(SUM_W'(1) <<< (SAT_W - 1));

  typedef enum logic [1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [CS_W-1:0]  x;
    logic signed [CS_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    op_t                    op;
    logic [1:0]             quad;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic signed [PT_W-1:0] pz;
    logic signed [PT_W-1:0] ox;
    logic signed [PT_W-1:0] oy;
    logic signed [PT_W-1:0] oz;
  } art_pay_t;

  // atan(2^-i) with 2^32 units to a full turn.
  function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      5'd30:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/art_ifs.sv
// Stream interfaces for the point request channel and the result channel.
interface art_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [15:0]        angle;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;

  modport source (
    output valid, operation, angle, point_x, point_y, point_z,
           offset_x, offset_y, offset_z,
    input  ready
  );
  modport sink (
    input  valid, operation, angle, point_x, point_y, point_z,
           offset_x, offset_y, offset_z,
    output ready
  );
endinterface

interface art_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic signed [31:0] result_z;

  modport source (
    output valid, result_x, result_y, result_z,
    input  ready
  );
  modport sink (
    input  valid, result_x, result_y, result_z,
    output ready
  );
endinterface

>>> rtl/art_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation with its own valid/ready stage.
module art_cordic_cell import art_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  iter_idx,
  input  logic              in_valid,
  output logic              in_ready,
  input  cordic_vec_t       in_vec,
  input  art_pay_t          in_pay,
  output logic              out_valid,
  input  logic              out_ready,
  output cordic_vec_t       out_vec,
  output art_pay_t          out_pay
);

  logic                    valid_r, valid_nxt;
  cordic_vec_t             vec_r, vec_nxt;
  art_pay_t                pay_r;
  logic                    accept;
  logic signed [CS_W-1:0]  dx, dy;
  logic signed [ANG_W-1:0] da;

  assign in_ready  = !valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_vec   = vec_r;
  assign out_pay   = pay_r;

  always_comb begin
    dx      = in_vec.y >>> iter_idx;
    dy      = in_vec.x >>> iter_idx;
    da      = $signed(ANG_W'(atan_turn(iter_idx)));
    vec_nxt = in_vec;
    // Rotate toward zero residual angle.
    if (!in_vec.z[ANG_W-1]) begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - da;
    end else begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + da;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vec_r <= vec_nxt;
      pay_r <= in_pay;
    end
  end

  a_drain_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(valid_r) |-> $past(out_ready))
    else $error("cell dropped a request that was not taken");

  a_residual_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (vec_r.z <= Z_BOUND && vec_r.z >= -Z_BOUND))
    else $error("residual angle left its convergence range");

endmodule

>>> rtl/art_combine.sv
// Quadrant fix-up, rotation products, rounding, offset add and saturation.
module art_combine import art_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cordic_vec_t            in_vec,
  input  art_pay_t               in_pay,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [PT_W-1:0] res_x,
  output logic signed [PT_W-1:0] res_y,
  output logic signed [PT_W-1:0] res_z
);

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic rdy1, rdy2, rdy3, ld1, ld2, ld3;

  logic signed [CS_W-1:0]   c_fix, s_fix;
  logic signed [PT_W-1:0]   a_sel, b_sel;
  logic signed [PROD_W-1:0] p_ac_r, p_bs_r, p_as_r, p_bc_r;
  logic signed [PROD_W-1:0] p_ac_nxt, p_bs_nxt, p_as_nxt, p_bc_nxt;
  art_pay_t                 pay1_r, pay2_r;

  logic signed [ACC_W-1:0]  acc_diff, acc_sum;
  logic signed [ROT_W-1:0]  rot_diff, rot_sum;
  logic signed [ROT_W-1:0]  rot_x_r, rot_y_r, rot_z_r;
  logic signed [ROT_W-1:0]  rot_x_nxt, rot_y_nxt, rot_z_nxt;

  logic signed [PT_W-1:0]   res_x_r, res_y_r, res_z_r;
  logic signed [PT_W-1:0]   res_x_nxt, res_y_nxt, res_z_nxt;

  function automatic logic signed [PT_W-1:0] sat_add(
    input logic signed [ROT_W-1:0] v,
    input logic signed [PT_W-1:0]  off
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] lim;
    s   = SUM_W'(v) + SUM_W'(off);
    lim = s;
    if (s > SAT_HI) begin
      lim = SAT_HI;
    end else if (s < SAT_LO) begin
      lim = SAT_LO;
    end
    return PT_W'(lim);
  endfunction

  // Each stage holds its request until the next one frees up.
  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign ld1       = in_valid && rdy1;
  assign ld2       = v1_r && rdy2;
  assign ld3       = v2_r && rdy3;
  assign in_ready  = rdy1;
  assign out_valid = v3_r;
  assign res_x     = res_x_r;
  assign res_y     = res_y_r;
  assign res_z     = res_z_r;

  always_comb begin
    v1_nxt = ld1 ? 1'b1 : (rdy2 ? 1'b0 : v1_r);
    v2_nxt = ld2 ? 1'b1 : (rdy3 ? 1'b0 : v2_r);
    v3_nxt = ld3 ? 1'b1 : (out_ready ? 1'b0 : v3_r);
  end

  // Stage 1: restore the quarter turns folded out before the CORDIC, then multiply.
  always_comb begin
    case (in_pay.quad)
      2'd1: begin
        c_fix = -in_vec.y;
        s_fix = in_vec.x;
      end
      2'd2: begin
        c_fix = -in_vec.x;
        s_fix = -in_vec.y;
      end
      2'd3: begin
        c_fix = in_vec.y;
        s_fix = -in_vec.x;
      end
      default: begin
        c_fix = in_vec.x;
        s_fix = in_vec.y;
      end
    endcase

    case (in_pay.op)
      OP_ROT_X: begin
        a_sel = in_pay.py;
        b_sel = in_pay.pz;
      end
      OP_ROT_Y: begin
        a_sel = in_pay.px;
        b_sel = in_pay.pz;
      end
      default: begin
        a_sel = in_pay.px;
        b_sel = in_pay.py;
      end
    endcase

    p_ac_nxt = PROD_W'(a_sel) * PROD_W'(c_fix);
    p_bs_nxt = PROD_W'(b_sel) * PROD_W'(s_fix);
    p_as_nxt = PROD_W'(a_sel) * PROD_W'(s_fix);
    p_bc_nxt = PROD_W'(b_sel) * PROD_W'(c_fix);
  end

  // Stage 2: combine the products and round half up to Q16.16.
  always_comb begin
    acc_diff = ACC_W'(p_ac_r) - ACC_W'(p_bs_r) + RND_HALF;
    acc_sum  = ACC_W'(p_as_r) + ACC_W'(p_bc_r) + RND_HALF;
    rot_diff = ROT_W'(acc_diff >>> FRAC_SHIFT);
    rot_sum  = ROT_W'(acc_sum >>> FRAC_SHIFT);

    rot_x_nxt = ROT_W'(pay1_r.px);
    rot_y_nxt = ROT_W'(pay1_r.py);
    rot_z_nxt = ROT_W'(pay1_r.pz);
    case (pay1_r.op)
      OP_ROT_X: begin
        rot_y_nxt = rot_diff;
        rot_z_nxt = rot_sum;
      end
      OP_ROT_Y: begin
        rot_x_nxt = rot_diff;
        rot_z_nxt = rot_sum;
      end
      OP_ROT_Z: begin
        rot_x_nxt = rot_diff;
        rot_y_nxt = rot_sum;
      end
      default: begin
        rot_x_nxt = ROT_W'(pay1_r.px);
      end
    endcase
  end

  // Stage 3: add the offset and clamp.
  always_comb begin
    res_x_nxt = sat_add(rot_x_r, pay2_r.ox);
    res_y_nxt = sat_add(rot_y_r, pay2_r.oy);
    res_z_nxt = sat_add(rot_z_r, pay2_r.oz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      p_ac_r <= p_ac_nxt;
      p_bs_r <= p_bs_nxt;
      p_as_r <= p_as_nxt;
      p_bc_r <= p_bc_nxt;
      pay1_r <= in_pay;
    end
    if (ld2) begin
      rot_x_r <= rot_x_nxt;
      rot_y_r <= rot_y_nxt;
      rot_z_r <= rot_z_nxt;
      pay2_r  <= pay1_r;
    end
    if (ld3) begin
      res_x_r <= res_x_nxt;
      res_y_r <= res_y_nxt;
      res_z_r <= res_z_nxt;
    end
  end

  a_no_axis_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && pay2_r.op == OP_NONE) |->
      (rot_x_r == ROT_W'(pay2_r.px) && rot_y_r == ROT_W'(pay2_r.py) &&
       rot_z_r == ROT_W'(pay2_r.pz)))
    else $error("point changed although no axis was selected");

  a_axis_coord_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && pay2_r.op == OP_ROT_X) |-> rot_x_r == ROT_W'(pay2_r.px))
    else $error("coordinate on the rotation axis was altered");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(v3_r) |-> $past(out_ready))
    else $error("result dropped before it was taken");

endmodule

>>> rtl/axis_rotate_translate.sv
// Top level: rotate a 3D point about one axis by a binary angle (or leave it unrotated), then add an offset.
// A request passes through every CORDIC cell and then the tail stages before its result is valid.
// Throughput: one request per cycle; each CORDIC cell and each tail stage is its own
// valid/ready register, so a stalled result only blocks once every stage ahead is full.
// Reset clears only the stage valid bits; the datapath registers are not reset.
module axis_rotate_translate import art_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  art_in_if.sink        in_chan,
  art_out_if.source     out_chan
);

  cordic_vec_t           stg_vec   [NUM_ITER+1];
  art_pay_t              stg_pay   [NUM_ITER+1];
  logic [NUM_ITER:0]     stg_valid;
  logic [NUM_ITER:0]     stg_ready;

  logic [ANGLE_W-1:0]        ang_biased;
  logic [1:0]                quad;
  logic [ANGLE_W-1:0]        ang_rem;
  cordic_vec_t               head_vec;
  art_pay_t                  head_pay;

  // Fold the angle to within an eighth turn; the quarter turns are restored later.
  always_comb begin
    ang_biased = in_chan.angle + ANGLE_W'(16'h2000);
    quad       = ang_biased[ANGLE_W-1:ANGLE_W-2];
    ang_rem    = in_chan.angle - {quad, (ANGLE_W-2)'(0)};

    head_vec.x = INV_GAIN;
    head_vec.y = '0;
    head_vec.z = ANG_W'($signed({ang_rem, 16'd0}));

    head_pay.op   = op_t'(in_chan.operation);
    head_pay.quad = quad;
    head_pay.px   = in_chan.point_x;
    head_pay.py   = in_chan.point_y;
    head_pay.pz   = in_chan.point_z;
    head_pay.ox   = in_chan.offset_x;
    head_pay.oy   = in_chan.offset_y;
    head_pay.oz   = in_chan.offset_z;
  end

  assign stg_vec[0]    = head_vec;
  assign stg_pay[0]    = head_pay;
  assign stg_valid[0]  = in_chan.valid;
  assign in_chan.ready = stg_ready[0];

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_cell
    art_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .iter_idx  (IDX_W'(i)),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_vec    (stg_vec[i]),
      .in_pay    (stg_pay[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_vec   (stg_vec[i+1]),
      .out_pay   (stg_pay[i+1])
    );
  end

  art_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid[NUM_ITER]),
    .in_ready  (stg_ready[NUM_ITER]),
    .in_vec    (stg_vec[NUM_ITER]),
    .in_pay    (stg_pay[NUM_ITER]),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .res_x     (out_chan.result_x),
    .res_y     (out_chan.result_y),
    .res_z     (out_chan.result_z)
  );

endmodule
